[hdl/tarp_pkg.sv]
// Shared types and constants for the three-axis rate PID.
// No dependencies; every other file of the block but tarp_if refers to this package.
package tarp_pkg;

  localparam int AXES        = 3;
  localparam int STICK_W     = 17;
  localparam int GAIN_W      = 24;
  localparam int GYRO_W      = 24;
  localparam int DT_W        = 20;
  localparam int LIMIT_W     = 31;
  localparam int THR_W       = 16;
  localparam int CFG_W       = 31;
  localparam int REG_IDX_W   = 3;
  localparam int RATE_PROD_W = 42;
  localparam int ERR_W       = 26;
  localparam int PROD_W      = 51;
  localparam int TERM_W      = 35;
  localparam int INC_PROD_W  = 56;
  localparam int INC_W       = 36;
  localparam int INTEG_W     = 37;
  localparam int ACC_W       = 32;
  localparam int DIFF_W      = 27;
  localparam int DPROD_W     = 52;
  localparam int DIV_W       = 55;
  localparam int DIV_CNT_W   = 6;
  localparam int D_W         = 56;
  localparam int TOTAL_W     = 58;
  localparam int OUT_W       = 32;

  localparam logic [THR_W-1:0] THROTTLE_CUTOFF_RST = 16'd13107;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_MAX_RATE_SCALE  = 3'd0,
    REG_GAIN_P          = 3'd1,
    REG_GAIN_I          = 3'd2,
    REG_GAIN_D          = 3'd3,
    REG_INTEGRAL_LIMIT  = 3'd4,
    REG_THROTTLE_CUTOFF = 3'd5
  } tarp_reg_t;

  typedef enum logic [2:0] {
    LN_IDLE,
    LN_ERR,
    LN_MUL,
    LN_KI,
    LN_INC,
    LN_INTEG,
    LN_WAIT,
    LN_DONE
  } tarp_lane_state_t;

  typedef struct packed {
    logic [GAIN_W-1:0]  max_rate_scale;
    logic [GAIN_W-1:0]  gain_p;
    logic [GAIN_W-1:0]  gain_i;
    logic [GAIN_W-1:0]  gain_d;
    logic [LIMIT_W-1:0] integral_limit;
    logic [THR_W-1:0]   throttle_cutoff;
  } tarp_cfg_t;

  typedef struct packed {
    logic signed [STICK_W-1:0] stick;
    logic signed [GYRO_W-1:0]  gyro;
    logic [DT_W-1:0]           dt;
    logic                      low_throttle;
  } tarp_lane_in_t;

  typedef struct packed {
    logic start;
    logic take;
  } tarp_lane_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } tarp_lane_sts_t;

endpackage

[hdl/tarp_if.sv]
// Valid/ready channel interfaces for the rate PID command and result.
// Depends on nothing; the top level takes them as ports through modports.
interface tarp_cmd_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] stick_pitch;
  logic signed [15:0] stick_yaw;
  logic signed [15:0] stick_roll;
  logic [15:0]        stick_throttle;
  logic signed [23:0] gyro_x;
  logic signed [23:0] gyro_y;
  logic signed [23:0] gyro_z;
  logic [19:0]        step_time;

  modport source (
    output valid, stick_pitch, stick_yaw, stick_roll, stick_throttle,
    output gyro_x, gyro_y, gyro_z, step_time,
    input  ready
  );
  modport sink (
    input  valid, stick_pitch, stick_yaw, stick_roll, stick_throttle,
    input  gyro_x, gyro_y, gyro_z, step_time,
    output ready
  );
endinterface

interface tarp_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] drive_x;
  logic signed [31:0] drive_y;
  logic signed [31:0] drive_z;

  modport source (output valid, drive_x, drive_y, drive_z, input ready);
  modport sink (input valid, drive_x, drive_y, drive_z, output ready);
endinterface

[hdl/three_axis_rate_pid.sv]
// Top level of the three-axis rate PID: config registers, three axis lanes, merge stage.
// Depends on tarp_pkg, tarp_if and tarp_lane.
//
//  channel  direction  transfer when              carries
//  cmd      in         cmd.valid & cmd.ready      sticks, throttle, gyro, step_time
//  result   out        result.valid & result.ready drive_x, drive_y, drive_z
//  cfg      in         cfg_we                     cfg_index, cfg_data
//
// The result becomes valid once the 55-step derivative divider in each lane is done;
// the three lanes run in lockstep.
// The next command can transfer in the cycle after the result loads.
// A new command is taken once the previous results sit in the output register.
// Reset is synchronous: gains and limit clear, cutoff returns to 0.2, axis state clears.
// A stalled result holds the output register and the finished lanes.
module three_axis_rate_pid (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [tarp_pkg::REG_IDX_W-1:0]    cfg_index,
  input  logic [tarp_pkg::CFG_W-1:0]        cfg_data,
  tarp_cmd_if.sink                          cmd,
  tarp_rsp_if.source                        result
);

  tarp_pkg::tarp_cfg_t                 cfg;
  tarp_pkg::tarp_lane_in_t             lane_in   [tarp_pkg::AXES];
  tarp_pkg::tarp_lane_sts_t            lane_sts  [tarp_pkg::AXES];
  logic signed [tarp_pkg::OUT_W-1:0]   lane_drive[tarp_pkg::AXES];
  tarp_pkg::tarp_lane_ctl_t            lane_ctl;
  logic                                running;
  logic                                accept;
  logic                                all_done;
  logic                                move;
  logic                                low_throttle;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_rate_scale  <= '0;
      cfg.gain_p          <= '0;
      cfg.gain_i          <= '0;
      cfg.gain_d          <= '0;
      cfg.integral_limit  <= '0;
      cfg.throttle_cutoff <= tarp_pkg::THROTTLE_CUTOFF_RST;
    end else if (cfg_we) begin
      unique case (tarp_pkg::tarp_reg_t'(cfg_index))
        tarp_pkg::REG_MAX_RATE_SCALE:  cfg.max_rate_scale  <= cfg_data[tarp_pkg::GAIN_W-1:0];
        tarp_pkg::REG_GAIN_P:          cfg.gain_p          <= cfg_data[tarp_pkg::GAIN_W-1:0];
        tarp_pkg::REG_GAIN_I:          cfg.gain_i          <= cfg_data[tarp_pkg::GAIN_W-1:0];
        tarp_pkg::REG_GAIN_D:          cfg.gain_d          <= cfg_data[tarp_pkg::GAIN_W-1:0];
        tarp_pkg::REG_INTEGRAL_LIMIT:  cfg.integral_limit  <= cfg_data[tarp_pkg::LIMIT_W-1:0];
        tarp_pkg::REG_THROTTLE_CUTOFF: cfg.throttle_cutoff <= cfg_data[tarp_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

  assign low_throttle = (cmd.stick_throttle < cfg.throttle_cutoff);

  always_comb begin
    lane_in[0].stick        = -$signed({cmd.stick_pitch[15], cmd.stick_pitch});
    lane_in[1].stick        = tarp_pkg::STICK_W'(cmd.stick_yaw);
    lane_in[2].stick        = tarp_pkg::STICK_W'(cmd.stick_roll);
    lane_in[0].gyro         = cmd.gyro_x;
    lane_in[1].gyro         = cmd.gyro_y;
    lane_in[2].gyro         = cmd.gyro_z;
    for (int i = 0; i < tarp_pkg::AXES; i++) begin
      lane_in[i].dt           = cmd.step_time;
      lane_in[i].low_throttle = low_throttle;
    end
  end

  assign cmd.ready = !running;
  assign accept    = cmd.valid && !running;
  assign all_done  = lane_sts[0].done && lane_sts[1].done && lane_sts[2].done;
  assign move      = running && all_done && (!result.valid || result.ready);

  assign lane_ctl.start = accept;
  assign lane_ctl.take  = move;

  for (genvar g = 0; g < tarp_pkg::AXES; g++) begin : g_lane
    tarp_lane u_lane (
      .clk   (clk),
      .rst   (rst),
      .cfg   (cfg),
      .lin   (lane_in[g]),
      .ctl   (lane_ctl),
      .sts   (lane_sts[g]),
      .drive (lane_drive[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running      <= 1'b0;
      result.valid <= 1'b0;
    end else begin
      if (accept) begin
        running <= 1'b1;
      end else if (move) begin
        running <= 1'b0;
      end
      if (move) begin
        result.valid <= 1'b1;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      result.drive_x <= lane_drive[0];
      result.drive_y <= lane_drive[1];
      result.drive_z <= lane_drive[2];
    end
  end

`ifndef SYNTHESIS
  a_lanes_lockstep: assert property (@(posedge clk) disable iff (rst)
    (lane_sts[0].done == lane_sts[1].done) && (lane_sts[1].done == lane_sts[2].done))
    else $error("axis lanes out of step");

  a_ready_lanes_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.ready |-> !(lane_sts[0].busy || lane_sts[1].busy || lane_sts[2].busy) ||
                  (lane_sts[0].done && lane_sts[1].done && lane_sts[2].done))
    else $error("command ready while lanes work");

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (cmd.valid && cmd.ready) |=> (lane_sts[0].busy && running))
    else $error("accepted command did not start lanes");

  a_move_frees: assert property (@(posedge clk) disable iff (rst)
    move |=> (result.valid && !running))
    else $error("result move did not load output");
`endif

endmodule

[hdl/tarp_div.sv]
// Restoring divider, one quotient bit per cycle, unsigned.
// Depends on tarp_pkg for widths.
module tarp_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [tarp_pkg::DIV_W-1:0]     numer,
  input  logic [tarp_pkg::DT_W-1:0]      denom,
  output logic [tarp_pkg::DIV_W-1:0]     quot,
  output logic                           done
);

  logic [tarp_pkg::DIV_W-1:0]     acc;
  logic [tarp_pkg::DT_W-1:0]      rem;
  logic [tarp_pkg::DT_W-1:0]      den;
  logic [tarp_pkg::DIV_CNT_W-1:0] cnt;
  logic                           busy;
  logic [tarp_pkg::DT_W:0]        rem_sh;
  logic [tarp_pkg::DT_W:0]        rem_sub;
  logic                           qbit;

  assign rem_sh  = {rem, acc[tarp_pkg::DIV_W-1]};
  assign rem_sub = rem_sh - {1'b0, den};
  assign qbit    = (rem_sh >= {1'b0, den});
  assign quot    = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == tarp_pkg::DIV_CNT_W'(tarp_pkg::DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc <= numer;
      rem <= '0;
      den <= denom;
    end else if (busy) begin
      acc <= {acc[tarp_pkg::DIV_W-2:0], qbit};
      rem <= qbit ? rem_sub[tarp_pkg::DT_W-1:0] : rem_sh[tarp_pkg::DT_W-1:0];
    end
  end

endmodule

[hdl/tarp_lane.sv]
// One axis of the rate PID: error, P, clamped integral, and D via divider.
// Depends on tarp_pkg and tarp_div.
module tarp_lane (
  input  logic                              clk,
  input  logic                              rst,
  input  tarp_pkg::tarp_cfg_t               cfg,
  input  tarp_pkg::tarp_lane_in_t           lin,
  input  tarp_pkg::tarp_lane_ctl_t          ctl,
  output tarp_pkg::tarp_lane_sts_t          sts,
  output logic signed [tarp_pkg::OUT_W-1:0] drive
);

  tarp_pkg::tarp_lane_state_t state, state_next;

  tarp_pkg::tarp_lane_in_t                    lin_q;
  logic signed [tarp_pkg::RATE_PROD_W-1:0]    rate_prod;
  logic signed [tarp_pkg::ERR_W-1:0]          err;
  logic signed [tarp_pkg::ERR_W-1:0]          prev_err;
  logic signed [tarp_pkg::ACC_W-1:0]          integral;
  logic signed [tarp_pkg::PROD_W-1:0]         p_prod;
  logic signed [tarp_pkg::PROD_W-1:0]         ki_prod;
  logic signed [tarp_pkg::DPROD_W-1:0]        d_prod;
  logic signed [tarp_pkg::TERM_W-1:0]         p_term;
  logic signed [tarp_pkg::TERM_W-1:0]         ki_e;
  logic signed [tarp_pkg::INC_PROD_W-1:0]     inc_prod;
  logic                                       d_neg;

  logic signed [tarp_pkg::RATE_PROD_W-1:0]    rate_rnd;
  logic signed [tarp_pkg::ERR_W-1:0]          rate;
  logic signed [tarp_pkg::ERR_W:0]            err_wide;
  logic signed [tarp_pkg::DIFF_W-1:0]         diff;
  logic signed [tarp_pkg::PROD_W-1:0]         p_rnd;
  logic signed [tarp_pkg::PROD_W-1:0]         ki_rnd;
  logic [tarp_pkg::DPROD_W-1:0]               d_mag;
  logic [tarp_pkg::DIV_W-1:0]                 numer;
  logic signed [tarp_pkg::INC_PROD_W-1:0]     inc_rnd;
  logic signed [tarp_pkg::INC_W-1:0]          inc;
  logic signed [tarp_pkg::INTEG_W-1:0]        integ_raw;
  logic signed [tarp_pkg::INTEG_W-1:0]        lim;
  logic signed [tarp_pkg::INTEG_W-1:0]        integ_c;
  logic signed [tarp_pkg::D_W-1:0]            d_term;
  logic signed [tarp_pkg::TOTAL_W-1:0]        total;
  logic signed [tarp_pkg::OUT_W-1:0]          sat;

  logic                                       div_start;
  logic                                       div_done;
  logic [tarp_pkg::DIV_W-1:0]                 quot;

  tarp_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .numer (numer),
    .denom (lin_q.dt),
    .quot  (quot),
    .done  (div_done)
  );

  assign rate_rnd = rate_prod + 42'sd16384;
  assign rate     = rate_rnd[tarp_pkg::ERR_W+14:15];
  assign err_wide = (tarp_pkg::ERR_W+1)'(rate) - (tarp_pkg::ERR_W+1)'(lin_q.gyro);
  assign diff     = tarp_pkg::DIFF_W'(err) - tarp_pkg::DIFF_W'(prev_err);
  assign p_rnd    = p_prod + 51'sd32768;
  assign ki_rnd   = ki_prod + 51'sd32768;
  assign d_mag    = d_prod[tarp_pkg::DPROD_W-1] ? -d_prod : d_prod;
  assign numer    = {d_mag[tarp_pkg::DIV_W-5:0], 4'b0000}
                    + tarp_pkg::DIV_W'(lin_q.dt >> 1);
  assign inc_rnd  = inc_prod + 56'sd524288;
  assign inc      = inc_rnd[tarp_pkg::INC_PROD_W-1:20];
  assign integ_raw = tarp_pkg::INTEG_W'(integral) + tarp_pkg::INTEG_W'(inc);
  assign lim      = $signed({6'b000000, cfg.integral_limit});

  always_comb begin
    integ_c = integ_raw;
    if (integ_raw > lim) integ_c = lim;
    if (integ_raw < -lim) integ_c = -lim;
    if (lin_q.low_throttle) integ_c = '0;
  end

  always_comb begin
    if (lin_q.dt == '0) begin
      d_term = '0;
    end else if (d_neg) begin
      d_term = -$signed({1'b0, quot});
    end else begin
      d_term = $signed({1'b0, quot});
    end
    total = tarp_pkg::TOTAL_W'(p_term) + tarp_pkg::TOTAL_W'(integral)
            + tarp_pkg::TOTAL_W'(d_term);
    if (total > 58'sd2147483647) begin
      sat = 32'sh7fffffff;
    end else if (total < -58'sd2147483648) begin
      sat = 32'sh80000000;
    end else begin
      sat = total[tarp_pkg::OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tarp_pkg::LN_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    sts.busy   = (state != tarp_pkg::LN_IDLE);
    sts.done   = (state == tarp_pkg::LN_DONE);
    unique case (state)
      tarp_pkg::LN_IDLE:  if (ctl.start) state_next = tarp_pkg::LN_ERR;
      tarp_pkg::LN_ERR:   state_next = tarp_pkg::LN_MUL;
      tarp_pkg::LN_MUL:   state_next = tarp_pkg::LN_KI;
      tarp_pkg::LN_KI: begin
        div_start  = 1'b1;
        state_next = tarp_pkg::LN_INC;
      end
      tarp_pkg::LN_INC:   state_next = tarp_pkg::LN_INTEG;
      tarp_pkg::LN_INTEG: state_next = tarp_pkg::LN_WAIT;
      tarp_pkg::LN_WAIT:  if (div_done) state_next = tarp_pkg::LN_DONE;
      tarp_pkg::LN_DONE:  if (ctl.take) state_next = tarp_pkg::LN_IDLE;
      default:            state_next = tarp_pkg::LN_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      integral <= '0;
      prev_err <= '0;
    end else begin
      if (state == tarp_pkg::LN_MUL) prev_err <= err;
      if (state == tarp_pkg::LN_INTEG) integral <= integ_c[tarp_pkg::ACC_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      tarp_pkg::LN_IDLE: begin
        if (ctl.start) begin
          lin_q     <= lin;
          rate_prod <= lin.stick * $signed({1'b0, cfg.max_rate_scale});
        end
      end
      tarp_pkg::LN_ERR: err <= err_wide[tarp_pkg::ERR_W-1:0];
      tarp_pkg::LN_MUL: begin
        p_prod  <= err * $signed({1'b0, cfg.gain_p});
        ki_prod <= err * $signed({1'b0, cfg.gain_i});
        d_prod  <= diff * $signed({1'b0, cfg.gain_d});
      end
      tarp_pkg::LN_KI: begin
        p_term <= p_rnd[tarp_pkg::PROD_W-1:16];
        ki_e   <= ki_rnd[tarp_pkg::PROD_W-1:16];
        d_neg  <= d_prod[tarp_pkg::DPROD_W-1];
      end
      tarp_pkg::LN_INC: inc_prod <= ki_e * $signed({1'b0, lin_q.dt});
      tarp_pkg::LN_WAIT: if (div_done) drive <= sat;
      default: ;
    endcase
  end

endmodule

[test/tb_top.sv]
// Testbench for three_axis_rate_pid: a directed table, then random phases under new gains.
// Results are checked against table values or a fixed-point rate PID model kept in step.
// Depends on tarp_pkg, tarp_if and the three_axis_rate_pid top level.
module tb_top;
  import tarp_pkg::*;

  localparam int QUIET_LIMIT = 4000;
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 60;
  localparam logic [REG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  typedef struct packed {
    logic signed [15:0] pitch;
    logic signed [15:0] yaw;
    logic signed [15:0] roll;
    logic [15:0]        throttle;
    logic signed [23:0] gx;
    logic signed [23:0] gy;
    logic signed [23:0] gz;
    logic [19:0]        dt;
  } stick_cmd_t;

  typedef logic [AXES-1:0][OUT_W-1:0] drive_t;

  typedef struct packed {
    stick_cmd_t c;
    logic       typed;
    drive_t     want;
  } cmd_entry_t;

  typedef enum logic {ROW_WRITE, ROW_ITEM} row_kind_t;

  typedef struct packed {
    row_kind_t              kind;
    logic [REG_IDX_W-1:0]   idx;
    logic [CFG_W-1:0]       data;
    cmd_entry_t             e;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [REG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  tarp_cmd_if cmd_ch ();
  tarp_rsp_if rsp_ch ();

  three_axis_rate_pid dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd_ch),
    .result    (rsp_ch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  tarp_cfg_t  pid_cfg;
  int         integ_acc [AXES];
  int         last_err [AXES];
  cmd_entry_t cmd_backlog [$];
  drive_t     drive_expect [$];
  plan_row_t  plan [$];
  int         errors = 0;
  int         drive_seen = 0;
  int         quiet = 0;
  string      axis_name [AXES] = '{"drive_x", "drive_y", "drive_z"};

  task automatic report(string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  function automatic longint round_sh(longint v, int sh);
    return (v + (longint'(1) <<< (sh - 1))) >>> sh;
  endfunction

  function automatic longint div_round(longint n, longint dv);
    longint mag;
    longint q;
    mag = (n < 0) ? -n : n;
    q = (mag + dv / 2) / dv;
    return (n < 0) ? -q : q;
  endfunction

  function automatic drive_t pid_step(stick_cmd_t c);
    longint stick_v [AXES];
    longint gyro [AXES];
    longint err, p, ki_e, inc, integ, d, total, dt, lim;
    logic   low;
    drive_t y;
    stick_v[0] = -longint'($signed(c.pitch));
    stick_v[1] = longint'($signed(c.yaw));
    stick_v[2] = longint'($signed(c.roll));
    gyro[0] = longint'($signed(c.gx));
    gyro[1] = longint'($signed(c.gy));
    gyro[2] = longint'($signed(c.gz));
    dt = longint'(c.dt);
    lim = longint'(pid_cfg.integral_limit);
    low = c.throttle < pid_cfg.throttle_cutoff;
    for (int a = 0; a < AXES; a++) begin
      err = round_sh(stick_v[a] * longint'(pid_cfg.max_rate_scale), 15) - gyro[a];
      p = round_sh(err * longint'(pid_cfg.gain_p), 16);
      ki_e = round_sh(err * longint'(pid_cfg.gain_i), 16);
      inc = round_sh(ki_e * dt, 20);
      integ = longint'(integ_acc[a]) + inc;
      if (integ > lim) integ = lim;
      if (integ < -lim) integ = -lim;
      if (low) integ = 0;
      integ_acc[a] = int'(integ);
      d = 0;
      if (dt != 0)
        d = div_round((err - longint'(last_err[a])) * longint'(pid_cfg.gain_d) * 16, dt);
      last_err[a] = int'(err);
      total = p + integ + d;
      if (total > 64'sd2147483647) total = 64'sd2147483647;
      if (total < -64'sd2147483648) total = -64'sd2147483648;
      y[a] = total[31:0];
    end
    return y;
  endfunction

  function automatic stick_cmd_t mk(int pitch, int yaw, int roll, int thr,
                                    int gx, int gy, int gz, int dt);
    stick_cmd_t c;
    c.pitch = 16'(pitch);
    c.yaw = 16'(yaw);
    c.roll = 16'(roll);
    c.throttle = 16'(thr);
    c.gx = 24'(gx);
    c.gy = 24'(gy);
    c.gz = 24'(gz);
    c.dt = 20'(dt);
    return c;
  endfunction

  function automatic void add_item(stick_cmd_t c);
    plan_row_t r;
    r = '0;
    r.kind = ROW_ITEM;
    r.e.c = c;
    plan.push_back(r);
  endfunction

  function automatic void add_item_exp(stick_cmd_t c, int x, int y, int z);
    plan_row_t r;
    r = '0;
    r.kind = ROW_ITEM;
    r.e.c = c;
    r.e.typed = 1'b1;
    r.e.want = {z, y, x};
    plan.push_back(r);
  endfunction

  function automatic void add_write(logic [REG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    plan_row_t r;
    r = '0;
    r.kind = ROW_WRITE;
    r.idx = idx;
    r.data = data;
    plan.push_back(r);
  endfunction

  function automatic int rand_stick();
    case ($urandom_range(0, 7))
      0: return -32768;
      1: return 32767;
      2: return 0;
      default: return int'($signed(16'($urandom)));
    endcase
  endfunction

  function automatic int rand_gyro();
    case ($urandom_range(0, 7))
      0: return -8388608;
      1: return 8388607;
      2, 3, 4: return int'($urandom_range(0, 131072)) - 65536;
      default: return int'($signed(24'($urandom)));
    endcase
  endfunction

  function automatic int rand_dt();
    case ($urandom_range(0, 15))
      0, 1: return 0;
      2: return 1048575;
      3: return 1;
      4, 5, 6, 7: return int'($urandom_range(1, 2000));
      default: return int'(20'($urandom));
    endcase
  endfunction

  function automatic stick_cmd_t rand_cmd();
    int thr;
    case ($urandom_range(0, 7))
      0: thr = 0;
      1: thr = 65535;
      default: thr = int'(16'($urandom));
    endcase
    return mk(rand_stick(), rand_stick(), rand_stick(), thr,
              rand_gyro(), rand_gyro(), rand_gyro(), rand_dt());
  endfunction

  function automatic logic [CFG_W-1:0] reg_pick(int phase, int w);
    if (phase == 0) return '1;
    if (phase == 1) return '0;
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return CFG_W'($urandom);
      default: return CFG_W'($urandom & ((32'd1 << $urandom_range(1, w)) - 32'd1));
    endcase
  endfunction

  task automatic settle();
    while (cmd_backlog.size() != 0 || drive_expect.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_MAX_RATE_SCALE:  pid_cfg.max_rate_scale = data[GAIN_W-1:0];
      REG_GAIN_P:          pid_cfg.gain_p = data[GAIN_W-1:0];
      REG_GAIN_I:          pid_cfg.gain_i = data[GAIN_W-1:0];
      REG_GAIN_D:          pid_cfg.gain_d = data[GAIN_W-1:0];
      REG_INTEGRAL_LIMIT:  pid_cfg.integral_limit = data[LIMIT_W-1:0];
      REG_THROTTLE_CUTOFF: pid_cfg.throttle_cutoff = data[THR_W-1:0];
      default: ;
    endcase
  endtask

  int gap_left = 0;
  int burst_left = 1;

  always @(posedge clk) begin : cmd_driver
    cmd_entry_t sent;
    drive_t     predicted;
    if (rst) begin
      cmd_ch.valid <= 1'b0;
      cmd_ch.stick_pitch <= '0;
      cmd_ch.stick_yaw <= '0;
      cmd_ch.stick_roll <= '0;
      cmd_ch.stick_throttle <= '0;
      cmd_ch.gyro_x <= '0;
      cmd_ch.gyro_y <= '0;
      cmd_ch.gyro_z <= '0;
      cmd_ch.step_time <= '0;
    end else begin
      if (cmd_ch.valid && cmd_ch.ready) begin
        sent = cmd_backlog.pop_front();
        predicted = pid_step(sent.c);
        drive_expect.push_back(sent.typed ? sent.want : predicted);
      end
      if (!(cmd_ch.valid && !cmd_ch.ready)) begin
        if (gap_left > 0) begin
          gap_left--;
          cmd_ch.valid <= 1'b0;
        end else if (cmd_backlog.size() > 0) begin
          cmd_ch.valid <= 1'b1;
          cmd_ch.stick_pitch <= cmd_backlog[0].c.pitch;
          cmd_ch.stick_yaw <= cmd_backlog[0].c.yaw;
          cmd_ch.stick_roll <= cmd_backlog[0].c.roll;
          cmd_ch.stick_throttle <= cmd_backlog[0].c.throttle;
          cmd_ch.gyro_x <= cmd_backlog[0].c.gx;
          cmd_ch.gyro_y <= cmd_backlog[0].c.gy;
          cmd_ch.gyro_z <= cmd_backlog[0].c.gz;
          cmd_ch.step_time <= cmd_backlog[0].c.dt;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 80) : 0;
          end
        end else begin
          cmd_ch.valid <= 1'b0;
        end
      end
    end
  end

  int rx_mode = 0;
  int rx_mode_left = 0;
  int stall_left = 0;
  int hold_left = 0;

  always @(posedge clk) begin : result_sink
    drive_t got;
    drive_t want;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        got = {rsp_ch.drive_z, rsp_ch.drive_y, rsp_ch.drive_x};
        if (drive_expect.size() == 0) begin
          report($sformatf("result transfer with nothing expected (%0d %0d %0d)",
                           $signed(got[0]), $signed(got[1]), $signed(got[2])));
        end else begin
          want = drive_expect.pop_front();
          for (int a = 0; a < AXES; a++)
            if (got[a] !== want[a])
              report($sformatf("result %0d %s got %0d want %0d", drive_seen, axis_name[a],
                               $signed(got[a]), $signed(want[a])));
        end
        drive_seen++;
        if (drive_seen % 200 == 60) hold_left = 400;
      end
      if (rx_mode_left == 0) begin
        rx_mode = $urandom_range(0, 2);
        rx_mode_left = $urandom_range(50, 400);
      end else begin
        rx_mode_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        case (rx_mode)
          0: rsp_ch.ready <= 1'b1;
          1: rsp_ch.ready <= 1'($urandom_range(0, 1));
          default: begin
            if (stall_left > 0) begin
              stall_left--;
              rsp_ch.ready <= 1'b0;
            end else begin
              rsp_ch.ready <= 1'b1;
              if ($urandom_range(0, 15) == 0) stall_left = $urandom_range(1, 90);
            end
          end
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (rst || cfg_we || (cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
      quiet = 0;
    else
      quiet++;
    if (quiet >= QUIET_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    pid_cfg = '0;
    pid_cfg.throttle_cutoff = THROTTLE_CUTOFF_RST;

    // zero gains after reset give zero drive
    add_item_exp(mk(-32768, 32767, -32768, 65535, 8388607, -8388608, 0, 1048575), 0, 0, 0);
    add_item_exp(mk(32767, -32768, 32767, 0, -8388608, 8388607, -1, 0), 0, 0, 0);
    // unit P gain, no stick scale: drive is minus gyro
    add_write(REG_GAIN_P, 31'd65536);
    add_item_exp(mk(0, 0, 0, 65535, 8388607, -8388608, 1, 0), -8388607, 8388608, -1);
    add_item_exp(mk(32767, -32768, 32767, 0, -8388608, 8388607, 0, 1048575),
                 8388608, -8388607, 0);
    // scale 32768 is unity: rate equals stick, pitch negated
    add_write(REG_MAX_RATE_SCALE, 31'd32768);
    add_item_exp(mk(-32768, 32767, -32768, 40000, 0, 0, 0, 1000), 32768, 32767, -32768);
    add_write(REG_GAIN_I, 31'd262144);
    add_write(REG_GAIN_D, 31'd65536);
    add_write(REG_INTEGRAL_LIMIT, 31'd100000);
    add_item(mk(1000, -2000, 3000, 65535, 500, -700, 0, 0));
    add_item(mk(0, 0, 0, 65535, -8388608, -8388608, -8388608, 1048575));
    add_item(mk(0, 0, 0, 65535, 8388607, 8388607, 8388607, 1048575));
    add_item(mk(0, 0, 0, 13106, 1000, -1000, 0, 4096));
    add_item(mk(0, 0, 0, 13107, 1000, -1000, 0, 4096));
    // full D and P gains with a one-tick step: saturate both ways
    add_write(REG_GAIN_D, 31'd16777215);
    add_write(REG_GAIN_P, 31'd16777215);
    add_item(mk(-32768, 32767, 32767, 65535, -8388608, -8388608, 8388607, 1));
    add_item(mk(32767, -32768, -32768, 65535, 8388607, 8388607, -8388608, 1));
    // unmapped indexes: drop
    add_write(REG_SPARE_LO, '1);
    add_write(REG_SPARE_HI, 31'd12345);
    add_write(REG_THROTTLE_CUTOFF, 31'd65535);
    add_write(REG_INTEGRAL_LIMIT, 31'h7FFFFFFF);
    add_item(mk(123, -456, 789, 65535, 1, 2, 3, 777));
    add_item(mk(-1, 1, -1, 65534, -1, -2, -3, 1048575));
    add_write(REG_THROTTLE_CUTOFF, 31'd0);
    add_item(mk(0, 0, 0, 0, 0, 0, 0, 1));

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_WRITE) begin
        settle();
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        cmd_backlog.push_back(plan[i].e);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      cmd_entry_t e;
      settle();
      write_reg(REG_MAX_RATE_SCALE, reg_pick(ph, GAIN_W));
      write_reg(REG_GAIN_P, reg_pick(ph, GAIN_W));
      write_reg(REG_GAIN_I, reg_pick(ph, GAIN_W));
      write_reg(REG_GAIN_D, reg_pick(ph, GAIN_W));
      write_reg(REG_INTEGRAL_LIMIT, reg_pick(ph, LIMIT_W));
      write_reg(REG_THROTTLE_CUTOFF, reg_pick(ph, THR_W));
      if ($urandom_range(0, 1) == 1) write_reg(REG_SPARE_HI, CFG_W'($urandom));
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        e = '0;
        e.c = rand_cmd();
        cmd_backlog.push_back(e);
      end
    end

    while (cmd_backlog.size() != 0 || drive_expect.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
